// File: src/accel_tilt_pitch_roll_unit_macros.svh
// Assertion macros for the tilt unit; expect clk_i and rst_ni in scope.
// Used by accel_tilt_pitch_roll_unit.sv; compiled out under SYNTHESIS.
`ifndef ACCEL_TILT_PITCH_ROLL_UNIT_MACROS_SVH
`define ACCEL_TILT_PITCH_ROLL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tilt unit check failed");
`define TPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tilt unit check failed");
`else
`define TPR_ASSERT_IMP(lbl, ante, cons)
`define TPR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/tpr_pkg.sv
// Shared types, constants and CORDIC step functions for the tilt unit.
// No dependencies; used by every module of the block.
package tpr_pkg;

  localparam int ANGLE_FRACTION_BITS = 7;
  localparam int CORDIC_STEPS        = 16;
  localparam int TABLE_LEN           = 24;
  localparam int TABLE_FRAC          = 24;
  localparam int GUARD_BITS          = 24;
  localparam int ITERS    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int WORD_W   = 46;
  localparam int ACC_W    = 32;
  localparam int ANGLE_W  = 15;
  localparam int SAMPLE_W = 16;
  localparam int RND_SH   = TABLE_FRAC - ANGLE_FRACTION_BITS;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(90 << ANGLE_FRACTION_BITS);

  localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115
  };

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    word_t a;
    word_t b;
  } pair_t;

  typedef struct packed {
    logic neg;
    logic num_zero;
    logic den_zero;
  } flags_t;

  typedef struct packed {
    flags_t pitch;
    flags_t roll;
  } side_t;

  typedef struct packed {
    pair_t u;
    pair_t v;
  } mag_t;

  typedef struct packed {
    mag_t  pitch;
    mag_t  roll;
    side_t side;
  } mag_beat_t;

  typedef struct packed {
    pair_t uv;
    acc_t  acc;
  } atn_t;

  typedef struct packed {
    atn_t  pitch;
    atn_t  roll;
    side_t side;
  } atn_beat_t;

  function automatic word_t lift(logic signed [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W:0] e;
    e = SAMPLE_W'(1) == 1 ? {s[SAMPLE_W-1], s} : {s[SAMPLE_W-1], s};
    if (e[SAMPLE_W]) begin
      e = -e;
    end
    return WORD_W'(e) <<< GUARD_BITS;
  endfunction

  function automatic pair_t rot(pair_t p, int unsigned sh);
    word_t a;
    word_t b;
    word_t ta;
    word_t tb;
    pair_t r;
    a  = p.a;
    b  = p.b;
    ta = a >>> sh;
    tb = b >>> sh;
    if (!b[WORD_W-1]) begin
      r.a = a + tb;
      r.b = b - ta;
    end else begin
      r.a = a - tb;
      r.b = b + ta;
    end
    return r;
  endfunction

  function automatic mag_beat_t mag_step(mag_beat_t m, int unsigned sh);
    mag_beat_t r;
    r         = m;
    r.pitch.u = rot(m.pitch.u, sh);
    r.pitch.v = rot(m.pitch.v, sh);
    r.roll.u  = rot(m.roll.u, sh);
    r.roll.v  = rot(m.roll.v, sh);
    return r;
  endfunction

  function automatic atn_t atn_rot(atn_t t, int unsigned sh);
    atn_t r;
    r.uv = rot(t.uv, sh);
    if (!t.uv.b[WORD_W-1]) begin
      r.acc = t.acc + ATAN_TAB[sh];
    end else begin
      r.acc = t.acc - ATAN_TAB[sh];
    end
    return r;
  endfunction

  function automatic atn_beat_t atn_step(atn_beat_t t, int unsigned sh);
    atn_beat_t r;
    r       = t;
    r.pitch = atn_rot(t.pitch, sh);
    r.roll  = atn_rot(t.roll, sh);
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] finish(acc_t acc, flags_t f);
    acc_t                       rs;
    logic signed [ANGLE_W-1:0]  res;
    rs = (acc + (acc_t'(1) <<< (RND_SH - 1))) >>> RND_SH;
    if (rs < 0) begin
      res = '0;
    end else if (rs > acc_t'(ANGLE_LIM)) begin
      res = ANGLE_LIM;
    end else begin
      res = rs[ANGLE_W-1:0];
    end
    if (f.den_zero) begin
      res = f.num_zero ? '0 : ANGLE_LIM;
    end else if (f.num_zero) begin
      res = '0;
    end
    return f.neg ? -res : res;
  endfunction

endpackage

// File: src/tpr_mag_pipe.sv
// Magnitude pipeline: one vectoring CORDIC iteration per register stage.
// Depends on tpr_pkg.
module tpr_mag_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tpr_pkg::mag_beat_t beat_i,
  output logic               valid_o,
  output tpr_pkg::mag_beat_t beat_o
);

  logic [tpr_pkg::ITERS-1:0] valid_q;
  tpr_pkg::mag_beat_t        beat_q [tpr_pkg::ITERS];
  logic [tpr_pkg::ITERS-1:0] src_valid;
  tpr_pkg::mag_beat_t        src    [tpr_pkg::ITERS];

  assign src_valid[0] = valid_i;
  assign src[0]       = beat_i;

  for (genvar k = 0; k < tpr_pkg::ITERS; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign src_valid[k] = valid_q[k-1];
      assign src[k]       = beat_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= src_valid[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        beat_q[k] <= tpr_pkg::mag_step(src[k], k);
      end
    end
  end

  assign valid_o = valid_q[tpr_pkg::ITERS-1];
  assign beat_o  = beat_q[tpr_pkg::ITERS-1];

endmodule

// File: src/tpr_atan_pipe.sv
// Arctangent pipeline: one CORDIC rotation and table add per register stage.
// Depends on tpr_pkg.
module tpr_atan_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tpr_pkg::atn_beat_t beat_i,
  output logic               valid_o,
  output tpr_pkg::atn_beat_t beat_o
);

  logic [tpr_pkg::ITERS-1:0] valid_q;
  tpr_pkg::atn_beat_t        beat_q [tpr_pkg::ITERS];
  logic [tpr_pkg::ITERS-1:0] src_valid;
  tpr_pkg::atn_beat_t        src    [tpr_pkg::ITERS];

  assign src_valid[0] = valid_i;
  assign src[0]       = beat_i;

  for (genvar k = 0; k < tpr_pkg::ITERS; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign src_valid[k] = valid_q[k-1];
      assign src[k]       = beat_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= src_valid[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        beat_q[k] <= tpr_pkg::atn_step(src[k], k);
      end
    end
  end

  assign valid_o = valid_q[tpr_pkg::ITERS-1];
  assign beat_o  = beat_q[tpr_pkg::ITERS-1];

endmodule

// File: src/accel_tilt_pitch_roll_unit.sv
// Top level of the tilt unit: input conditioning, the two CORDIC pipelines
// and the output register. Depends on tpr_pkg, tpr_mag_pipe, tpr_atan_pipe.
//
// Usage:
//   Slave channel s_axis carries one accelerometer sample per beat,
//   x, y, z as signed 16-bit counts. Master channel m_axis returns
//   pitch and roll in degrees with 7 fraction bits, one beat per sample,
//   in order.
//   Between the accepted input beat and the output beat, each magnitude
//   and each arctangent iteration is one register stage, plus the output
//   register.
//   Throughput is one sample per cycle while the pipeline is not held.
//   All stages advance together while the output register is empty or
//   being taken; when m_axis_tready is low with a valid output, the whole
//   pipeline holds and s_axis_tready falls.
//   Reset clears every valid bit; the data registers are not reset.
`include "accel_tilt_pitch_roll_unit_macros.svh"
module accel_tilt_pitch_roll_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // pitch_angle [14:0], roll_angle [29:15], zero pad
);

  logic                                     en;
  logic signed [tpr_pkg::SAMPLE_W-1:0]      ax;
  logic signed [tpr_pkg::SAMPLE_W-1:0]      ay;
  logic signed [tpr_pkg::SAMPLE_W-1:0]      az;
  tpr_pkg::word_t                           lx;
  tpr_pkg::word_t                           ly;
  tpr_pkg::word_t                           lz;
  tpr_pkg::mag_beat_t                       mag_in;
  tpr_pkg::mag_beat_t                       mag_out;
  logic                                     mag_valid;
  tpr_pkg::atn_beat_t                       atn_in;
  tpr_pkg::atn_beat_t                       atn_out;
  logic                                     atn_valid;
  logic                                     out_valid_q;
  logic signed [tpr_pkg::ANGLE_W-1:0]       pitch_q;
  logic signed [tpr_pkg::ANGLE_W-1:0]       roll_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign ax = s_axis_tdata[15:0];
  assign ay = s_axis_tdata[31:16];
  assign az = s_axis_tdata[47:32];
  assign lx = tpr_pkg::lift(ax);
  assign ly = tpr_pkg::lift(ay);
  assign lz = tpr_pkg::lift(az);

  always_comb begin
    mag_in.pitch.u.a = ly;
    mag_in.pitch.u.b = lz;
    mag_in.pitch.v.a = lx;
    mag_in.pitch.v.b = '0;
    mag_in.roll.u.a  = lx;
    mag_in.roll.u.b  = lz;
    mag_in.roll.v.a  = ly;
    mag_in.roll.v.b  = '0;
    mag_in.side.pitch.neg      = ax[tpr_pkg::SAMPLE_W-1];
    mag_in.side.pitch.num_zero = (ax == '0);
    mag_in.side.pitch.den_zero = (ay == '0) && (az == '0);
    mag_in.side.roll.neg       = ay[tpr_pkg::SAMPLE_W-1];
    mag_in.side.roll.num_zero  = (ay == '0);
    mag_in.side.roll.den_zero  = (ax == '0) && (az == '0);
  end

  tpr_mag_pipe u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .beat_i  (mag_in),
    .valid_o (mag_valid),
    .beat_o  (mag_out)
  );

  always_comb begin
    atn_in.pitch.uv.a = mag_out.pitch.u.a;
    atn_in.pitch.uv.b = mag_out.pitch.v.a;
    atn_in.pitch.acc  = '0;
    atn_in.roll.uv.a  = mag_out.roll.u.a;
    atn_in.roll.uv.b  = mag_out.roll.v.a;
    atn_in.roll.acc   = '0;
    atn_in.side       = mag_out.side;
  end

  tpr_atan_pipe u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mag_valid),
    .beat_i  (atn_in),
    .valid_o (atn_valid),
    .beat_o  (atn_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= atn_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_q <= tpr_pkg::finish(atn_out.pitch.acc, atn_out.side.pitch);
      roll_q  <= tpr_pkg::finish(atn_out.roll.acc, atn_out.side.roll);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, roll_q, pitch_q};

  `TPR_ASSERT_IMP(a_pitch_range, out_valid_q, (pitch_q <= tpr_pkg::ANGLE_LIM) && (pitch_q >= -tpr_pkg::ANGLE_LIM))
  `TPR_ASSERT_IMP(a_roll_range, out_valid_q, (roll_q <= tpr_pkg::ANGLE_LIM) && (roll_q >= -tpr_pkg::ANGLE_LIM))
  `TPR_ASSERT_IMP(a_empty_ready, !out_valid_q, s_axis_tready)
  `TPR_ASSERT_NXT(a_hold_out, out_valid_q && !m_axis_tready, out_valid_q && (pitch_q == $past(pitch_q)))

endmodule
